@@ design/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, codes and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] BLANK_CODE   = 8'd32;
	localparam logic [7:0] RESET_ATTR   = 8'd15;

	// configuration register index
	localparam int REG_DEFAULT_ATTR = 0;

	typedef enum logic [1:0] {
		ACT_PUT        = 2'd0,
		ACT_CLEAR      = 2'd1,
		ACT_SET_CURSOR = 2'd2,
		ACT_READ       = 2'd3
	} act_t;

	typedef struct packed {
		logic        valid;
		logic [11:0] cursor_offset;
		logic [7:0]  cell_char;
		logic [7:0]  cell_attr;
		logic        did_scroll;
		logic        bad_position;
	} result_t;

	function automatic logic [15:0] make_cell(input logic [7:0] ch, input logic [7:0] at);
		return {at, ch};
	endfunction

endpackage

@@ design/tcw_mem.sv @@
// ----------------------------------------------------------------------------
// tcw_mem
// Screen cell store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcw_mem import tcw_pkg::*; #(
	parameter int DEPTH = COLUMNS_DEF * ROWS_DEF,
	parameter int AW    = $clog2(COLUMNS_DEF * ROWS_DEF),
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/tcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer of the console: one shared adder drives cursor moves, fill and
// scroll sweeps and the column recovery after a cursor set.
// ----------------------------------------------------------------------------
module tcw_ctrl import tcw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF,
	localparam int CELLS  = COLUMNS * ROWS,
	localparam int AW     = $clog2(CELLS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [1:0]    action,
	input  logic [7:0]    char_code,
	input  logic [7:0]    attribute,
	input  logic [11:0]   position,
	input  logic [7:0]    default_attr,
	output logic          busy,
	output result_t       res,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [15:0]   mem_wdata,
	output logic          mem_re,
	output logic [AW-1:0] mem_raddr,
	input  logic [15:0]   mem_rdata
);

	localparam int CW   = $clog2(CELLS + 1);
	localparam int COLW = $clog2(COLUMNS);
	localparam int SW   = CW + 1;
	localparam int CMPW = ((CW > 12) ? CW : 12) + 1;
	localparam logic [AW-1:0] LAST_ADDR   = AW'(CELLS - 1);
	localparam logic [AW-1:0] SCROLL_BASE = AW'(CELLS - COLUMNS);
	localparam logic [SW-1:0] NEG_COLS    = SW'(0) - SW'(COLUMNS);

	typedef enum logic [7:0] {
		S_INIT   = 8'b00000001,
		S_IDLE   = 8'b00000010,
		S_EXEC   = 8'b00000100,
		S_RDWAIT = 8'b00001000,
		S_DIV    = 8'b00010000,
		S_FILL   = 8'b00100000,
		S_COPY   = 8'b01000000,
		S_DRAIN  = 8'b10000000
	} state_t;

	state_t          state_q;
	act_t            act_q;
	logic [7:0]      chr_q;
	logic [7:0]      attr_q;
	logic [11:0]     pos_q;
	logic [CW-1:0]   cursor_q;
	logic [COLW-1:0] col_q;
	logic [AW-1:0]   idx_q;
	logic [AW-1:0]   dst_q;
	logic            wr_vld_s1;
	logic [CW-1:0]   rem_q;
	logic            scroll_q;
	result_t         res_q;

	logic [SW-1:0]   alu_a;
	logic [SW-1:0]   alu_b;
	logic [SW-1:0]   alu_sum;
	logic            is_newline;
	logic            pos_bad;
	logic [7:0]      attr_eff;
	logic [CW-1:0]   cursor_nxt;

	function automatic result_t mk_res(input logic [CW-1:0] cur, input logic [7:0] ch,
			input logic [7:0] at, input logic sc, input logic bad);
		result_t r;
		r.valid         = 1'b1;
		r.cursor_offset = 12'(cur);
		r.cell_char     = ch;
		r.cell_attr     = at;
		r.did_scroll    = sc;
		r.bad_position  = bad;
		return r;
	endfunction

	assign is_newline = (chr_q == NEWLINE_CODE);
	assign pos_bad    = (CMPW'(pos_q) >= CMPW'(CELLS));
	assign attr_eff   = (attr_q == 8'd0) ? default_attr : attr_q;

	// shared adder
	always_comb begin
		case (state_q)
			S_EXEC: begin
				alu_a = SW'(cursor_q);
				alu_b = is_newline ? (SW'(COLUMNS) - SW'(col_q)) : SW'(1);
			end
			S_DIV: begin
				alu_a = SW'(rem_q);
				alu_b = NEG_COLS;
			end
			default: begin
				alu_a = SW'(idx_q);
				alu_b = SW'(1);
			end
		endcase
		alu_sum = alu_a + alu_b;
	end

	assign cursor_nxt = alu_sum[CW-1:0];

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = make_cell(BLANK_CODE, default_attr);
		mem_re    = 1'b0;
		mem_raddr = idx_q;
		case (state_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = make_cell(BLANK_CODE, RESET_ATTR);
			end
			S_FILL: begin
				mem_we = 1'b1;
			end
			S_EXEC: begin
				if (act_q == ACT_PUT && !is_newline) begin
					mem_we    = 1'b1;
					mem_waddr = AW'(cursor_q);
					mem_wdata = make_cell(chr_q, attr_eff);
				end
				if (act_q == ACT_READ && !pos_bad) begin
					mem_re    = 1'b1;
					mem_raddr = AW'(pos_q);
				end
			end
			S_COPY: begin
				mem_re    = 1'b1;
				mem_we    = wr_vld_s1;
				mem_waddr = dst_q;
				mem_wdata = mem_rdata;
			end
			S_DRAIN: begin
				mem_we    = 1'b1;
				mem_waddr = dst_q;
				mem_wdata = mem_rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			cursor_q  <= '0;
			col_q     <= '0;
			idx_q     <= '0;
			dst_q     <= '0;
			wr_vld_s1 <= 1'b0;
			rem_q     <= '0;
			scroll_q  <= 1'b0;
			res_q     <= '0;
		end else begin
			case (state_q)
				S_INIT: begin
					if (idx_q == LAST_ADDR) begin
						idx_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						idx_q <= alu_sum[AW-1:0];
					end
				end
				S_IDLE: begin
					// every result beat lands in idle, so drop it here
					res_q.valid <= 1'b0;
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (act_q)
						ACT_PUT: begin
							if (alu_sum == SW'(CELLS)) begin
								cursor_q  <= CW'(CELLS - COLUMNS);
								col_q     <= '0;
								idx_q     <= AW'(COLUMNS);
								dst_q     <= '0;
								wr_vld_s1 <= 1'b0;
								scroll_q  <= 1'b1;
								state_q   <= S_COPY;
							end else begin
								if (is_newline || col_q == COLW'(COLUMNS - 1)) begin
									col_q <= '0;
								end else begin
									col_q <= col_q + COLW'(1);
								end
								cursor_q <= cursor_nxt;
								res_q    <= mk_res(cursor_nxt, 8'd0, 8'd0, 1'b0, 1'b0);
								state_q  <= S_IDLE;
							end
						end
						ACT_CLEAR: begin
							cursor_q <= '0;
							col_q    <= '0;
							idx_q    <= '0;
							scroll_q <= 1'b0;
							state_q  <= S_FILL;
						end
						ACT_SET_CURSOR: begin
							if (pos_bad) begin
								res_q   <= mk_res(cursor_q, 8'd0, 8'd0, 1'b0, 1'b1);
								state_q <= S_IDLE;
							end else begin
								cursor_q <= CW'(pos_q);
								rem_q    <= CW'(pos_q);
								state_q  <= S_DIV;
							end
						end
						ACT_READ: begin
							if (pos_bad) begin
								res_q   <= mk_res(cursor_q, 8'd0, 8'd0, 1'b0, 1'b1);
								state_q <= S_IDLE;
							end else begin
								state_q <= S_RDWAIT;
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_RDWAIT: begin
					res_q   <= mk_res(cursor_q, mem_rdata[7:0], mem_rdata[15:8], 1'b0, 1'b0);
					state_q <= S_IDLE;
				end
				S_DIV: begin
					// strip one row per cycle until the column is left
					if (SW'(rem_q) >= SW'(COLUMNS)) begin
						rem_q <= alu_sum[CW-1:0];
					end else begin
						col_q   <= COLW'(rem_q);
						res_q   <= mk_res(cursor_q, 8'd0, 8'd0, 1'b0, 1'b0);
						state_q <= S_IDLE;
					end
				end
				S_COPY: begin
					idx_q     <= alu_sum[AW-1:0];
					wr_vld_s1 <= 1'b1;
					if (wr_vld_s1) begin
						dst_q <= dst_q + AW'(1);
					end
					if (idx_q == LAST_ADDR) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					// last moved beat lands here, then blank the bottom row
					wr_vld_s1 <= 1'b0;
					idx_q     <= SCROLL_BASE;
					state_q   <= S_FILL;
				end
				S_FILL: begin
					idx_q <= alu_sum[AW-1:0];
					if (idx_q == LAST_ADDR) begin
						res_q   <= mk_res(cursor_q, 8'd0, 8'd0, scroll_q, 1'b0);
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			act_q  <= act_t'(action);
			chr_q  <= char_code;
			attr_q <= attribute;
			pos_q  <= position;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign res  = res_q;

endmodule

@@ design/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: character/attribute screen store, cursor, scroll, and
// a configuration register for the default attribute.
// ----------------------------------------------------------------------------
// A put or newline goes from EXEC straight to done, a read adds RDWAIT,
// a cursor set loops in DIV (one row stripped per adder pass), a clear
// sweeps the store in FILL; a scrolling put shifts rows up in COPY, one
// store cell per cycle over the single write port, then blanks the last row.
// A new start is taken in the cycle done is high. The receiver cannot stall.
// Reset: cursor 0; busy stays high while the store
// is swept to blanks with attribute 15.
module text_console_writer import tcw_pkg::*; #(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic [1:0]  action,
	input  logic [7:0]  char_code,
	input  logic [7:0]  attribute,
	input  logic [11:0] position,
	output logic [11:0] cursor_offset,
	output logic [7:0]  cell_char,
	output logic [7:0]  cell_attr,
	output logic        did_scroll,
	output logic        bad_position,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);

	logic [7:0]    default_attr_q;
	logic          reg_sel;
	result_t       res;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [15:0]   mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [15:0]   mem_rdata;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == 1'(REG_DEFAULT_ATTR));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_attr_q <= RESET_ATTR;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			default_attr_q <= pwdata[7:0];
		end
	end

	assign prdata = reg_sel ? {24'd0, default_attr_q} : 32'd0;

	tcw_ctrl #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.action      (action),
		.char_code   (char_code),
		.attribute   (attribute),
		.position    (position),
		.default_attr(default_attr_q),
		.busy        (busy),
		.res         (res),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	tcw_mem #(
		.DEPTH(CELLS),
		.AW   (AW),
		.DW   (16)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign done          = res.valid;
	assign cursor_offset = res.cursor_offset;
	assign cell_char     = res.cell_char;
	assign cell_attr     = res.cell_attr;
	assign did_scroll    = res.did_scroll;
	assign bad_position  = res.bad_position;

endmodule
